// File: rtl/scaled_decimal_amount_alu_top_macros.svh
// assertion macros for the scaled decimal amount alu
// used by scaled_decimal_amount_alu_top; expects clk_i and rst_ni in scope
`ifndef SCALED_DECIMAL_AMOUNT_ALU_TOP_MACROS_SVH
`define SCALED_DECIMAL_AMOUNT_ALU_TOP_MACROS_SVH

// same-cycle implication
`define SDAA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDAA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sdaa_pkg.sv
// shared constants, codes and control structs of the scaled decimal amount alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdaa_pkg;

  localparam int unsigned ValueWords = 4;
  localparam int unsigned MaxWords   = 4;
  localparam int unsigned WordW      = 64;
  localparam int unsigned ValueW     = ValueWords * WordW;
  localparam int unsigned MaxW       = MaxWords * WordW;
  localparam int unsigned PrecW      = 8;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned DigCntW    = $clog2(ValueWords + 1);

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_SUB     = 2'd1,
    REQ_CMP     = 2'd2,
    REQ_RESCALE = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK            = 3'd0,
    ST_SCALE_OVF     = 3'd1,
    ST_SUM_OVF       = 3'd2,
    ST_MINUEND_SMALL = 3'd3,
    ST_PREC_SHRINK   = 3'd4
  } status_e;

  localparam logic signed [1:0] ORD_LESS    = 2'sb11;
  localparam logic signed [1:0] ORD_EQ      = 2'sb00;
  localparam logic signed [1:0] ORD_GREATER = 2'sb01;

  typedef struct packed {
    logic             start;
    logic [PrecW-1:0] digits;
  } scale_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ok;
  } scale_stat_t;

  typedef struct packed {
    logic start;
    logic sub;
  } ser_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic carry;
    logic nonzero;
  } ser_stat_t;

endpackage

`default_nettype wire

// File: rtl/sdaa_scale.sv
// decimal scaler: multiplies a value by ten once per cycle, one decimal digit a step
// depends on sdaa_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdaa_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sdaa_pkg::scale_ctrl_t       ctrl_i,
  input  logic [sdaa_pkg::ValueW-1:0] value_i,
  output sdaa_pkg::scale_stat_t       stat_o,
  output logic [sdaa_pkg::ValueW-1:0] value_o
);
  import sdaa_pkg::*;

  localparam int unsigned ExtW = ValueW + 4;

  logic              busy_q, done_q, ok_q;
  logic [ValueW-1:0] val_q;
  logic [PrecW-1:0]  cnt_q;
  logic [ExtW-1:0]   ext, prod;
  logic              finish, ovf;

  // v * 10 = v * 8 + v * 2, four spare bits catch the carry out
  always_comb begin
    ext    = ExtW'(val_q);
    prod   = (ext << 3) + (ext << 1);
    ovf    = (prod[ExtW-1:ValueW] != 4'd0);
    finish = (cnt_q == '0) || (val_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && (finish || ovf)) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      val_q <= value_i;
      cnt_q <= ctrl_i.digits;
      ok_q  <= 1'b1;
    end else if (busy_q) begin
      if (finish) begin
        ok_q <= 1'b1;
      end else if (ovf) begin
        ok_q <= 1'b0;
      end else begin
        val_q <= prod[ValueW-1:0];
        cnt_q <= cnt_q - PrecW'(1);
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.ok   = ok_q;
  assign value_o     = val_q;

endmodule

`default_nettype wire

// File: rtl/sdaa_serial.sv
// word-serial adder / subtractor, one 64-bit digit per cycle, least significant first
// depends on sdaa_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdaa_serial (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sdaa_pkg::ser_ctrl_t         ctrl_i,
  input  logic [sdaa_pkg::ValueW-1:0] a_i,
  input  logic [sdaa_pkg::ValueW-1:0] b_i,
  output sdaa_pkg::ser_stat_t         stat_o,
  output logic [sdaa_pkg::ValueW-1:0] value_o
);
  import sdaa_pkg::*;

  logic               busy_q, done_q;
  logic [DigCntW-1:0] cnt_q;
  logic [ValueW-1:0]  a_q, b_q, res_q, res_d;
  logic               sub_q, c_q, nz_q;
  logic [WordW-1:0]   dig_a, dig_b;
  logic [WordW:0]     sum;

  // subtract as a + ~b + 1, the carry in set at load
  always_comb begin
    dig_a = a_q[WordW-1:0];
    dig_b = sub_q ? ~b_q[WordW-1:0] : b_q[WordW-1:0];
    sum   = {1'b0, dig_a} + {1'b0, dig_b} + {{WordW{1'b0}}, c_q};
    res_d = res_q >> WordW;
    res_d[ValueW-1 -: WordW] = sum[WordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DigCntW'(ValueWords);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DigCntW'(1);
      if (cnt_q == DigCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      sub_q <= ctrl_i.sub;
      c_q   <= ctrl_i.sub;
      nz_q  <= 1'b0;
    end else if (busy_q) begin
      a_q   <= a_q >> WordW;
      b_q   <= b_q >> WordW;
      res_q <= res_d;
      c_q   <= sum[WordW];
      nz_q  <= nz_q | (sum[WordW-1:0] != '0);
    end
  end

  assign stat_o.busy    = busy_q;
  assign stat_o.done    = done_q;
  assign stat_o.carry   = c_q;
  assign stat_o.nonzero = nz_q;
  assign value_o        = res_q;

endmodule

`default_nettype wire

// File: rtl/scaled_decimal_amount_alu_top.sv
// scaled decimal amount alu: add, subtract, compare and rescale of 256-bit decimal amounts
// top level; depends on sdaa_pkg, sdaa_scale, sdaa_serial and the assertion macro header
//
// usage
//   input channel : in_valid_i / in_stall_o, one beat carries the request type, both
//                   operand values as four 64-bit words each and both precisions
//   output channel: out_valid_o / out_stall_i, one beat per request with the result
//                   value, its precision, a status code and the compare order
//   a beat moves on a rising edge with valid high and stall low
// timing
//   the block works on one request at a time; in_stall_o is high from acceptance
//   until the result has been handed to the output register
//   add, subtract and compare scale the lower-precision operand, then run the
//   serial pass; scaling stops early on a zero value or on overflow, and no nonzero
//   value takes more than 77 times-ten steps without overflow
//   rescale and scaling failures skip the serial pass, a refused rescale skips both
//   the scaler takes one digit per cycle, and the add / subtract / compare pass
//   takes one 64-bit word per cycle over the four words
// stall and reset
//   a result waiting under out_stall_i holds steady; the next request is still
//   taken and computed, and waits in its own result register until the output frees
//   reset clears the sequencer, the output valid and the sub-units' busy and done flags
`timescale 1ns / 1ps
`default_nettype none

`include "scaled_decimal_amount_alu_top_macros.svh"

module scaled_decimal_amount_alu_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request side
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         req_type_i,
  input  logic [sdaa_pkg::WordW-1:0]         a_word0_i,
  input  logic [sdaa_pkg::WordW-1:0]         a_word1_i,
  input  logic [sdaa_pkg::WordW-1:0]         a_word2_i,
  input  logic [sdaa_pkg::WordW-1:0]         a_word3_i,
  input  logic [sdaa_pkg::PrecW-1:0]         a_prec_i,
  input  logic [sdaa_pkg::WordW-1:0]         b_word0_i,
  input  logic [sdaa_pkg::WordW-1:0]         b_word1_i,
  input  logic [sdaa_pkg::WordW-1:0]         b_word2_i,
  input  logic [sdaa_pkg::WordW-1:0]         b_word3_i,
  input  logic [sdaa_pkg::PrecW-1:0]         b_prec_i,
  // result side
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sdaa_pkg::WordW-1:0]         r_word0_o,
  output logic [sdaa_pkg::WordW-1:0]         r_word1_o,
  output logic [sdaa_pkg::WordW-1:0]         r_word2_o,
  output logic [sdaa_pkg::WordW-1:0]         r_word3_o,
  output logic [sdaa_pkg::PrecW-1:0]         r_prec_o,
  output logic [sdaa_pkg::StatusW-1:0]       status_o,
  output logic signed [1:0]                  order_o
);
  import sdaa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCALE = 4'b0010,
    S_ARITH = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // request as it arrives
  logic [MaxW-1:0]   a_all, b_all;
  logic [ValueW-1:0] a_in, b_in;
  req_e              in_req;
  logic              in_acc, shrink, in_scale_b;

  // request kept while it is worked on
  req_e              req_q;
  logic [ValueW-1:0] a_q, b_q;
  logic [PrecW-1:0]  bp_q, mp_q;
  logic              scale_b_q;

  // result waiting for the output register
  logic              res_load;
  logic [ValueW-1:0] res_val_q, res_val_d;
  logic [PrecW-1:0]  res_prec_q, res_prec_d;
  status_e           res_status_q, res_status_d;
  logic signed [1:0] res_ord_q, res_ord_d;

  // output register
  logic              out_valid_q, out_load, out_acc;
  logic [ValueW-1:0] out_val_q;
  logic [PrecW-1:0]  out_prec_q;
  status_e           out_status_q;
  logic signed [1:0] out_ord_q;
  logic [MaxW-1:0]   out_all;

  // sub-units
  scale_ctrl_t       scl_ctrl;
  scale_stat_t       scl_stat;
  logic [ValueW-1:0] scl_val;
  ser_ctrl_t         ser_ctrl;
  ser_stat_t         ser_stat;
  logic [ValueW-1:0] ser_val;
  logic [ValueW-1:0] ser_a, ser_b;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  // words above the value width are dropped
  assign a_all  = {a_word3_i, a_word2_i, a_word1_i, a_word0_i};
  assign b_all  = {b_word3_i, b_word2_i, b_word1_i, b_word0_i};
  assign a_in   = a_all[ValueW-1:0];
  assign b_in   = b_all[ValueW-1:0];
  assign in_req = req_e'(req_type_i);

  // rescale refuses a smaller target; otherwise the lower-precision side is scaled
  assign shrink     = (in_req == REQ_RESCALE) && (a_prec_i > b_prec_i);
  assign in_scale_b = (in_req != REQ_RESCALE) && (a_prec_i >= b_prec_i);

  always_comb begin
    scl_ctrl.start  = in_acc && !shrink;
    scl_ctrl.digits = in_scale_b ? (a_prec_i - b_prec_i) : (b_prec_i - a_prec_i);
  end

  sdaa_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scl_ctrl),
    .value_i (in_scale_b ? b_in : a_in),
    .stat_o  (scl_stat),
    .value_o (scl_val)
  );

  // the scaled operand feeds the word-serial pass straight from the scaler
  assign ser_a = scale_b_q ? a_q : scl_val;
  assign ser_b = scale_b_q ? scl_val : b_q;

  sdaa_serial u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ser_ctrl),
    .a_i     (ser_a),
    .b_i     (ser_b),
    .stat_o  (ser_stat),
    .value_o (ser_val)
  );

  // sequencer
  always_comb begin
    state_d        = state_q;
    res_load       = 1'b0;
    res_val_d      = '0;
    res_prec_d     = '0;
    res_status_d   = ST_OK;
    res_ord_d      = ORD_EQ;
    ser_ctrl.start = 1'b0;
    ser_ctrl.sub   = (req_q != REQ_ADD);
    out_load       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (shrink) begin
            res_load     = 1'b1;
            res_status_d = ST_PREC_SHRINK;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        if (scl_stat.done) begin
          case (req_q)
            REQ_RESCALE: begin
              res_load = 1'b1;
              if (scl_stat.ok) begin
                res_val_d  = scl_val;
                res_prec_d = bp_q;
              end else begin
                res_status_d = ST_SCALE_OVF;
              end
              state_d = S_DONE;
            end
            REQ_CMP: begin
              if (scl_stat.ok) begin
                ser_ctrl.start = 1'b1;
                state_d        = S_ARITH;
              end else begin
                // the side that would not scale is the greater one
                res_load  = 1'b1;
                res_ord_d = scale_b_q ? ORD_LESS : ORD_GREATER;
                state_d   = S_DONE;
              end
            end
            default: begin
              if (scl_stat.ok) begin
                ser_ctrl.start = 1'b1;
                state_d        = S_ARITH;
              end else begin
                res_load     = 1'b1;
                res_status_d = ST_SCALE_OVF;
                state_d      = S_DONE;
              end
            end
          endcase
        end
      end
      S_ARITH: begin
        if (ser_stat.done) begin
          res_load = 1'b1;
          state_d  = S_DONE;
          case (req_q)
            REQ_ADD: begin
              if (ser_stat.carry) begin
                res_status_d = ST_SUM_OVF;
              end else begin
                res_val_d  = ser_val;
                res_prec_d = mp_q;
              end
            end
            REQ_SUB: begin
              // no carry out of a + ~b + 1 means a borrow
              if (!ser_stat.carry) begin
                res_status_d = ST_MINUEND_SMALL;
              end else begin
                res_val_d  = ser_val;
                res_prec_d = mp_q;
              end
            end
            REQ_CMP: begin
              if (!ser_stat.carry) begin
                res_ord_d = ORD_LESS;
              end else if (ser_stat.nonzero) begin
                res_ord_d = ORD_GREATER;
              end else begin
                res_ord_d = ORD_EQ;
              end
            end
            default: begin
              res_ord_d = ORD_EQ;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= in_req;
      a_q       <= a_in;
      b_q       <= b_in;
      bp_q      <= b_prec_i;
      mp_q      <= (a_prec_i > b_prec_i) ? a_prec_i : b_prec_i;
      scale_b_q <= in_scale_b;
    end
    if (res_load) begin
      res_val_q    <= res_val_d;
      res_prec_q   <= res_prec_d;
      res_status_q <= res_status_d;
      res_ord_q    <= res_ord_d;
    end
    if (out_load) begin
      out_val_q    <= res_val_q;
      out_prec_q   <= res_prec_q;
      out_status_q <= res_status_q;
      out_ord_q    <= res_ord_q;
    end
  end

  // unused upper words read as zero
  assign out_all     = MaxW'(out_val_q);
  assign out_valid_o = out_valid_q;
  assign r_word0_o   = out_all[0*WordW +: WordW];
  assign r_word1_o   = out_all[1*WordW +: WordW];
  assign r_word2_o   = out_all[2*WordW +: WordW];
  assign r_word3_o   = out_all[3*WordW +: WordW];
  assign r_prec_o    = out_prec_q;
  assign status_o    = out_status_q;
  assign order_o     = out_ord_q;

  // any error beat carries a zero amount and precision
  `SDAA_ASSERT_NOW(a_err_zero, out_valid_q && (out_status_q != ST_OK),
                   (out_val_q == '0) && (out_prec_q == '0), "error beat with nonzero amount")
  // an order other than equal comes only from a compare, which gives no amount
  `SDAA_ASSERT_NOW(a_ord_cmp, out_valid_q && (out_ord_q != ORD_EQ),
                   (out_status_q == ST_OK) && (out_val_q == '0) && (out_prec_q == '0),
                   "order set on a non-compare beat")
  // the sub-units only report back in the state that waits for them
  `SDAA_ASSERT_NOW(a_scl_done, scl_stat.done, state_q == S_SCALE, "scaler done out of step")
  `SDAA_ASSERT_NOW(a_ser_done, ser_stat.done, state_q == S_ARITH, "serial pass done out of step")
  // a started serial pass is busy the cycle after
  `SDAA_ASSERT_NEXT(a_ser_start, ser_ctrl.start, ser_stat.busy && (state_q == S_ARITH),
                    "serial pass did not start")

endmodule

`default_nettype wire
